@@ rtl/utf8_validate_or_repair_core_assert.svh @@
// ----------------------------------------------------------------------------
// utf8_validate_or_repair_core_assert.svh
// Assertion macros used by the checker file of the UTF-8 validator.
// ----------------------------------------------------------------------------
`ifndef UTF8_VALIDATE_OR_REPAIR_CORE_ASSERT_SVH
`define UTF8_VALIDATE_OR_REPAIR_CORE_ASSERT_SVH

// same-cycle implication
`define UTF8V_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define UTF8V_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/utf8v_pkg.sv @@
// ----------------------------------------------------------------------------
// utf8v_pkg
// Types and constants shared by the UTF-8 validate/repair core.
// ----------------------------------------------------------------------------
package utf8v_pkg;

   localparam int MAX_WORDS      = 6;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int OUT_OFFSET_BITS = 32;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_INVALID   = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

   localparam logic [7:0] LEAD2_LO     = 8'hC2;
   localparam logic [7:0] LEAD2_HI     = 8'hDF;
   localparam logic [7:0] LEAD3_LO     = 8'hE0;
   localparam logic [7:0] LEAD3_HI     = 8'hEF;
   localparam logic [7:0] LEAD4_LO     = 8'hF0;
   localparam logic [7:0] LEAD4_HI     = 8'hF4;
   localparam logic [7:0] LEAD_E0      = 8'hE0;
   localparam logic [7:0] LEAD_ED      = 8'hED;
   localparam logic [7:0] LEAD_F0      = 8'hF0;
   localparam logic [7:0] LEAD_F4      = 8'hF4;
   localparam logic [7:0] E0_CONT_MIN  = 8'hA0;
   localparam logic [7:0] ED_CONT_MAX  = 8'h9F;
   localparam logic [7:0] F0_CONT_MIN  = 8'h90;
   localparam logic [7:0] F4_CONT_MAX  = 8'h8F;
   localparam logic [7:0] ASCII_LIMIT  = 8'h80;
   localparam logic [1:0] CONT_TAG     = 2'b10;
   localparam logic [7:0] REPL_BYTE0   = 8'hEF;
   localparam logic [7:0] REPL_BYTE1   = 8'hBF;
   localparam logic [7:0] REPL_BYTE2   = 8'hBD;

   // one queue entry: all words caused by one input byte
   typedef struct packed {
      logic [MAX_WORDS-1:0][7:0]   bytes;
      logic [2:0]                  count;
      logic                        present;
      logic                        done;
      logic [1:0]                  status;
      logic [OUT_OFFSET_BITS-1:0]  offset;
   } cmd_type;

endpackage

@@ rtl/utf8v_req_if.sv @@
// ----------------------------------------------------------------------------
// utf8v_req_if
// Input byte channel: valid/ready with one stream byte and its end mark.
// ----------------------------------------------------------------------------
interface utf8v_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;

   modport source (output valid, in_byte, end_of_input, input ready);
   modport sink (input valid, in_byte, end_of_input, output ready);
endinterface

@@ rtl/utf8v_rsp_if.sv @@
// ----------------------------------------------------------------------------
// utf8v_rsp_if
// Result channel: valid/ready with one output byte and stream status.
// ----------------------------------------------------------------------------
interface utf8v_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        byte_present;
   logic [1:0]  status;
   logic [31:0] error_offset;
   logic        stream_done;
   logic        run_last;

   modport source (output valid, out_byte, byte_present, status, error_offset,
                   stream_done, run_last, input ready);
   modport sink (input valid, out_byte, byte_present, status, error_offset,
                 stream_done, run_last, output ready);
endinterface

@@ rtl/utf8v_front.sv @@
// ----------------------------------------------------------------------------
// utf8v_front
// Decoder: classifies each accepted byte and builds at most one queue entry.
// ----------------------------------------------------------------------------
module utf8v_front
   import utf8v_pkg::*;
#(
   parameter int OFFSET_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    lossy_mode,
   input  logic    in_valid,
   input  logic [7:0] in_byte,
   input  logic    end_of_input,
   output logic    in_ready,
   input  logic    cmd_full,
   output logic    cmd_push,
   output cmd_type cmd
);

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_COLLECT = 2'd1;
   localparam logic [1:0] PH_SKIP    = 2'd2;

   typedef struct packed {
      logic [MAX_WORDS-1:0][7:0] bytes;
      logic [2:0]                cnt;
   } acc_type;

   function automatic acc_type put_byte(acc_type a, logic [7:0] b);
      acc_type r;
      r = a;
      if (r.cnt < 3'(MAX_WORDS)) begin
         r.bytes[r.cnt] = b;
         r.cnt = r.cnt + 3'd1;
      end
      return r;
   endfunction

   function automatic acc_type put_repl(acc_type a);
      acc_type r;
      r = put_byte(a, REPL_BYTE0);
      r = put_byte(r, REPL_BYTE1);
      r = put_byte(r, REPL_BYTE2);
      return r;
   endfunction

   logic [1:0]             phase_ff, phase_in;
   logic [7:0]             lead_ff, lead_in;
   logic [2:0]             seq_len_ff, seq_len_in;
   logic [1:0]             collected_ff, collected_in;
   logic [2:0][7:0]        held_ff, held_in;
   logic                   pend_inv_ff, pend_inv_in;
   logic [1:0]             pend_rem_ff, pend_rem_in;
   logic [OFFSET_BITS-1:0] seq_start_ff, seq_start_in;
   logic [OFFSET_BITS-1:0] byte_pos_ff, byte_pos_in;
   logic [1:0]             err_code_ff, err_code_in;
   logic [OFFSET_BITS-1:0] err_pos_ff, err_pos_in;

   acc_type                    acc;
   logic                       cont;
   logic                       ok;
   logic                       do_lead;
   logic [2:0]                 rem;
   logic [1:0]                 status_c;
   logic [OUT_OFFSET_BITS-1:0] offs;
   logic [63:0]                err_wide;
   logic [2:0]                 n_words;
   logic                       accept;

   always_comb begin
      phase_in     = phase_ff;
      lead_in      = lead_ff;
      seq_len_in   = seq_len_ff;
      collected_in = collected_ff;
      held_in      = held_ff;
      pend_inv_in  = pend_inv_ff;
      pend_rem_in  = pend_rem_ff;
      seq_start_in = seq_start_ff;
      err_code_in  = err_code_ff;
      err_pos_in   = err_pos_ff;
      acc          = '0;
      ok           = 1'b0;
      do_lead      = 1'b0;
      rem          = '0;
      status_c     = STATUS_OK;
      offs         = '0;
      err_wide     = '0;
      cont         = (in_byte[7:6] == CONT_TAG);

      // settle a pending error once its sequence would have completed
      if (pend_inv_in) begin
         if (pend_rem_in != 2'd0) begin
            pend_rem_in = pend_rem_in - 2'd1;
         end
         if (pend_rem_in == 2'd0) begin
            pend_inv_in = 1'b0;
            err_code_in = STATUS_INVALID;
         end
      end

      if (!(phase_in == PH_SKIP && cont)) begin
         if (phase_in != PH_COLLECT || seq_len_in < 3'd2 || seq_len_in > 3'd4 ||
             collected_in == 2'd3) begin
            do_lead = 1'b1;
         end else begin
            ok = cont;
            if (ok && collected_in == 2'd0) begin
               if (lead_in == LEAD_E0 && in_byte < E0_CONT_MIN) ok = 1'b0;
               if (lead_in == LEAD_ED && in_byte > ED_CONT_MAX) ok = 1'b0;
               if (lead_in == LEAD_F0 && in_byte < F0_CONT_MIN) ok = 1'b0;
               if (lead_in == LEAD_F4 && in_byte > F4_CONT_MAX) ok = 1'b0;
            end
            if (ok) begin
               held_in[collected_in] = in_byte;
               collected_in = collected_in + 2'd1;
               if ({1'b0, collected_in} + 3'd1 == seq_len_in) begin
                  acc = put_byte(acc, lead_in);
                  for (int i = 0; i < 3; i++) begin
                     if (2'(i) < collected_in) acc = put_byte(acc, held_in[i]);
                  end
                  collected_in = 2'd0;
                  phase_in = PH_IDLE;
               end
            end else begin
               rem = seq_len_in - 3'd2 - {1'b0, collected_in};
               if (err_code_in == STATUS_OK && !pend_inv_in) begin
                  err_pos_in = seq_start_in;
                  if (rem == 3'd0) begin
                     err_code_in = STATUS_INVALID;
                  end else begin
                     pend_inv_in = 1'b1;
                     pend_rem_in = rem[1:0];
                  end
               end
               acc = put_repl(acc);
               collected_in = 2'd0;
               if (cont) begin
                  phase_in = PH_SKIP;
               end else begin
                  phase_in = PH_IDLE;
                  do_lead = 1'b1;
               end
            end
         end
      end

      if (do_lead) begin
         priority if (in_byte < ASCII_LIMIT) begin
            acc = put_byte(acc, in_byte);
            phase_in = PH_IDLE;
         end else if (in_byte >= LEAD2_LO && in_byte <= LEAD2_HI) begin
            seq_len_in = 3'd2;
         end else if (in_byte >= LEAD3_LO && in_byte <= LEAD3_HI) begin
            seq_len_in = 3'd3;
         end else if (in_byte >= LEAD4_LO && in_byte <= LEAD4_HI) begin
            seq_len_in = 3'd4;
         end else begin
            if (err_code_in == STATUS_OK && !pend_inv_in) begin
               err_pos_in = byte_pos_ff;
               err_code_in = STATUS_INVALID;
            end
            acc = put_repl(acc);
            phase_in = PH_SKIP;
         end
         if (in_byte >= LEAD2_LO && in_byte <= LEAD4_HI) begin
            lead_in = in_byte;
            collected_in = 2'd0;
            seq_start_in = byte_pos_ff;
            phase_in = PH_COLLECT;
         end
      end

      byte_pos_in = (&byte_pos_ff) ? byte_pos_ff : byte_pos_ff + OFFSET_BITS'(1);

      if (end_of_input) begin
         if (phase_in == PH_COLLECT) begin
            if (err_code_in == STATUS_OK && !pend_inv_in) begin
               err_pos_in = seq_start_in;
               pend_inv_in = 1'b1;
               pend_rem_in = 2'd1;
            end
            acc = put_repl(acc);
         end
         if (pend_inv_in) begin
            pend_inv_in = 1'b0;
            err_code_in = STATUS_TRUNCATED;
         end
         status_c = err_code_in;
         err_wide = 64'(err_pos_in);
         if (status_c != STATUS_OK) begin
            offs = (|err_wide[63:32]) ? '1 : err_wide[31:0];
         end
      end
   end

   assign accept   = in_valid && in_ready;
   assign in_ready = !cmd_full;
   assign n_words  = lossy_mode ? acc.cnt : 3'd0;
   assign cmd_push = accept && (n_words != 3'd0 || end_of_input);

   always_comb begin
      cmd.bytes   = lossy_mode ? acc.bytes : '0;
      cmd.count   = (n_words == 3'd0) ? 3'd1 : n_words;
      cmd.present = (n_words != 3'd0);
      cmd.done    = end_of_input;
      cmd.status  = status_c;
      cmd.offset  = offs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         lead_ff      <= '0;
         seq_len_ff   <= '0;
         collected_ff <= '0;
         pend_inv_ff  <= 1'b0;
         pend_rem_ff  <= '0;
         seq_start_ff <= '0;
         byte_pos_ff  <= '0;
         err_code_ff  <= STATUS_OK;
         err_pos_ff   <= '0;
      end else if (accept) begin
         if (end_of_input) begin
            phase_ff     <= PH_IDLE;
            lead_ff      <= '0;
            seq_len_ff   <= '0;
            collected_ff <= '0;
            pend_inv_ff  <= 1'b0;
            pend_rem_ff  <= '0;
            seq_start_ff <= '0;
            byte_pos_ff  <= '0;
            err_code_ff  <= STATUS_OK;
            err_pos_ff   <= '0;
         end else begin
            phase_ff     <= phase_in;
            lead_ff      <= lead_in;
            seq_len_ff   <= seq_len_in;
            collected_ff <= collected_in;
            pend_inv_ff  <= pend_inv_in;
            pend_rem_ff  <= pend_rem_in;
            seq_start_ff <= seq_start_in;
            byte_pos_ff  <= byte_pos_in;
            err_code_ff  <= err_code_in;
            err_pos_ff   <= err_pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule

@@ rtl/utf8v_queue.sv @@
// ----------------------------------------------------------------------------
// utf8v_queue
// Small FIFO of decoded entries between the decoder and the word sender.
// ----------------------------------------------------------------------------
module utf8v_queue
   import utf8v_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output cmd_type head,
   output logic    empty,
   output logic    full
);

   cmd_type                   mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + QUEUE_CNT_BITS'(1);
      if (do_pop && !do_push) count_in = count_ff - QUEUE_CNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/utf8v_back.sv @@
// ----------------------------------------------------------------------------
// utf8v_back
// Word sender: walks the head entry and hands out one word per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module utf8v_back
   import utf8v_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     head,
   input  logic        head_valid,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  out_byte,
   output logic        byte_present,
   output logic [1:0]  status,
   output logic [31:0] error_offset,
   output logic        stream_done,
   output logic        run_last
);

   logic [2:0] idx_ff, idx_in;
   logic       last_word;
   logic       fire;

   assign last_word    = (idx_ff == head.count - 3'd1);
   assign fire         = head_valid && rsp_ready;
   assign pop          = fire && last_word;
   assign rsp_valid    = head_valid;
   assign out_byte     = head.bytes[idx_ff];
   assign byte_present = head.present;
   assign run_last     = last_word;
   assign stream_done  = head.done && last_word;
   assign status       = (head.done && last_word) ? head.status : STATUS_OK;
   assign error_offset = (head.done && last_word) ? head.offset : '0;

   // advance within the entry, restart on the next one
   always_comb begin
      idx_in = idx_ff;
      if (fire) idx_in = last_word ? 3'd0 : idx_ff + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

@@ rtl/utf8_validate_or_repair_core.sv @@
// ----------------------------------------------------------------------------
// utf8_validate_or_repair_core
// UTF-8 stream validator with optional repair by replacement characters.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  req     | in  | in_byte, end_of_input
//  rsp     | out | out_byte, byte_present, status, error_offset, stream_done,
//          |     | run_last
//  csr     | in  | lossy_mode write (csr_wr_en, csr_wr_data)
//
//  A byte is taken every cycle while the 4-entry queue has room.
//  Each byte yields 0 to 6 words, sent one per cycle while rsp is ready;
//  a byte's first word is offered once its queue entry reaches the head.
//  Long repair bursts are bounded by the one-word-per-cycle sender.
//  Reset clears control state, not stored bytes; a stalled rsp holds its word.
// ----------------------------------------------------------------------------
module utf8_validate_or_repair_core
   import utf8v_pkg::*;
#(
   parameter int OFFSET_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   utf8v_req_if.sink   req_chan,
   utf8v_rsp_if.source rsp_chan
);

   logic    lossy_mode_ff, lossy_mode_in;
   cmd_type cmd;
   cmd_type head;
   logic    cmd_push;
   logic    cmd_pop;
   logic    q_empty;
   logic    q_full;

   assign lossy_mode_in = csr_wr_en ? csr_wr_data : lossy_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lossy_mode_ff <= 1'b0;
      end else begin
         lossy_mode_ff <= lossy_mode_in;
      end
   end

   utf8v_front #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .lossy_mode   (lossy_mode_ff),
      .in_valid     (req_chan.valid),
      .in_byte      (req_chan.in_byte),
      .end_of_input (req_chan.end_of_input),
      .in_ready     (req_chan.ready),
      .cmd_full     (q_full),
      .cmd_push     (cmd_push),
      .cmd          (cmd)
   );

   utf8v_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd),
      .pop       (cmd_pop),
      .head      (head),
      .empty     (q_empty),
      .full      (q_full)
   );

   utf8v_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .head_valid   (!q_empty),
      .pop          (cmd_pop),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .out_byte     (rsp_chan.out_byte),
      .byte_present (rsp_chan.byte_present),
      .status       (rsp_chan.status),
      .error_offset (rsp_chan.error_offset),
      .stream_done  (rsp_chan.stream_done),
      .run_last     (rsp_chan.run_last)
   );

endmodule

@@ rtl/utf8v_checker.sv @@
// ----------------------------------------------------------------------------
// utf8v_checker
// Port-level checks on the result channel of the validate/repair core.
// ----------------------------------------------------------------------------
`include "utf8_validate_or_repair_core_assert.svh"

module utf8v_checker
   import utf8v_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  out_byte,
   input logic        byte_present,
   input logic [1:0]  status,
   input logic [31:0] error_offset,
   input logic        stream_done,
   input logic        run_last
);

   logic       word_empty;
   logic       empty_ends;
   logic       done_word;
   logic       shows_error;
   logic       error_legal;
   logic       stalled;
   logic [9:0] held;

   assign word_empty  = rsp_valid && !byte_present;
   assign empty_ends  = stream_done && run_last && out_byte == 8'd0;
   assign done_word   = rsp_valid && stream_done;
   assign shows_error = rsp_valid && (error_offset != 32'd0 || status != STATUS_OK);
   assign error_legal = stream_done && (status == STATUS_INVALID || status == STATUS_TRUNCATED);
   assign stalled     = rsp_valid && !rsp_ready;
   assign held        = {out_byte, run_last, stream_done};

   `UTF8V_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "word after reset")

   `UTF8V_ASSERT_IMPLY(a_empty_word_ends, clock, reset, word_empty, empty_ends, "empty word early")

   `UTF8V_ASSERT_IMPLY(a_done_is_last, clock, reset, done_word, run_last, "done word not last")

   `UTF8V_ASSERT_IMPLY(a_offset_on_error, clock, reset, shows_error, error_legal, "early status")

   `UTF8V_ASSERT_NEXT(a_stall_hold, clock, reset, stalled, rsp_valid && $stable(held), "word moved")

endmodule

bind utf8_validate_or_repair_core utf8v_checker u_utf8v_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .out_byte     (rsp_chan.out_byte),
   .byte_present (rsp_chan.byte_present),
   .status       (rsp_chan.status),
   .error_offset (rsp_chan.error_offset),
   .stream_done  (rsp_chan.stream_done),
   .run_last     (rsp_chan.run_last)
);
